>>> design/pmb_pkg.sv
// shared types, constants and helper functions for the projection matrix builder
`default_nettype none
package pmb_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int IN_DATA_BITS  = 192;
    localparam int OUT_DATA_BITS = 40;
    localparam int CORDIC_STEPS  = 31;
    localparam int RANGE_STEPS   = 14;

    // projection kinds as they arrive on the input
    localparam logic [1:0] FUNC_ORTHO  = 2'd0;
    localparam logic [1:0] FUNC_FRUST  = 2'd1;
    localparam logic [1:0] FUNC_PERSP  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // classified work for the back end
    localparam logic [1:0] MODE_IDENT = 2'd0;
    localparam logic [1:0] MODE_ORTHO = 2'd1;
    localparam logic [1:0] MODE_FRUST = 2'd2;
    localparam logic [1:0] MODE_PERSP = 2'd3;

    localparam logic signed [31:0] ONE_FIX     = 32'sd65536;
    localparam logic signed [31:0] NEG_ONE_FIX = -32'sd65536;
    localparam logic [31:0]        POS_MAX     = 32'h7fff_ffff;
    localparam logic [31:0]        NEG_MAX     = 32'h8000_0000;

    // angles in Q.31 radians
    localparam logic [46:0] PI_Q31      = 47'd6746518852;
    localparam logic [32:0] HALF_PI_Q31 = 33'd3373259426;

    typedef logic [15:0][31:0] mat_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [32:0] sx;
        logic signed [32:0] sy;
        logic signed [32:0] sz;
        logic [63:0]        fn;
        logic               fn_neg;
        logic signed [31:0] zn;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] a3;
        logic signed [31:0] a4;
    } desc_t;

    typedef struct packed {
        logic [63:0] num;
        logic [5:0]  shift;
        logic [33:0] den;
        logic        neg;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
        logic        sat;
    } div_rsp_t;

    // arctangent of 2^-i in Q.31
    function automatic logic [31:0] atan_q31(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd1686629713;
            5'd1:    a = 32'd995675659;
            5'd2:    a = 32'd526087673;
            5'd3:    a = 32'd267050317;
            5'd4:    a = 32'd134043374;
            5'd5:    a = 32'd67087031;
            5'd6:    a = 32'd33551702;
            5'd7:    a = 32'd16776875;
            5'd8:    a = 32'd8388565;
            5'd9:    a = 32'd4194299;
            5'd10:   a = 32'd2097151;
            default: a = 32'h8000_0000 >> i;
        endcase
        return a;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage
`default_nettype wire

>>> design/projection_matrix_builder.sv
// top level of the projection matrix builder
//
//  channel  | direction | tdata / tuser contents (lowest bit first)
//  s_*      | in        | first_arg, second_arg, third_arg, fourth_arg, near_plane,
//           |           | far_plane / func
//  m_*      | out       | element_index, element_value, 4 zero bits / degenerate;
//           |           | tlast = last_element
//
// orthographic and frustum items each take six divisions on the shared divider,
// a perspective item runs an angle reduction, 31 cordic steps and four divisions,
// and the identity case takes no division.
// a two-entry queue accepts new items while one is computed; while the next one is
// computed, a finished matrix is sent at one element per cycle when m_tready is high.
// reset is asynchronous, active low, and empties the queue and all pipelines.
`default_nettype none
module projection_matrix_builder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,  // first_arg, second_arg, third_arg, fourth_arg,
                                        // near_plane, far_plane
    input  wire logic [1:0]   s_tuser,  // func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,  // element_index, element_value, zero pad
    output logic              m_tlast,
    output logic [0:0]        m_tuser   // degenerate
);
    import pmb_pkg::*;

    logic     q_valid, q_pop;
    desc_t    q_desc;
    logic     div_start;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     emit_idle, hand_valid, degen;
    mat_t     mat;

    // classification and queue
    pmb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_desc   (q_desc)
    );

    // shared divider
    pmb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // matrix computation
    pmb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_desc     (q_desc),
        .q_pop      (q_pop),
        .div_start  (div_start),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .emit_idle  (emit_idle),
        .hand_valid (hand_valid),
        .mat_out    (mat),
        .degen_out  (degen)
    );

    // element output
    pmb_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (hand_valid),
        .mat_in   (mat),
        .degen_in (degen),
        .idle     (emit_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

>>> design/pmb_front.sv
// input side: extents, sums, far*near product, kind check and a two-entry queue
`default_nettype none
module pmb_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [191:0]          s_tdata,
    input  wire logic [1:0]            s_tuser,
    output logic                       q_valid,
    input  wire logic                  q_pop,
    output pmb_pkg::desc_t             q_desc
);
    import pmb_pkg::*;

    logic signed [31:0] a1, a2, a3, a4, zn, zf;
    desc_t              d_in;
    desc_t              q_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg, count_next;
    logic               push;

    // classify and precompute
    always_comb
    begin
        a1 = s_tdata[31:0];
        a2 = s_tdata[63:32];
        a3 = s_tdata[95:64];
        a4 = s_tdata[127:96];
        zn = s_tdata[159:128];
        zf = s_tdata[191:160];
        d_in.dx     = 33'(a2) - 33'(a1);
        d_in.dy     = 33'(a4) - 33'(a3);
        d_in.dz     = 33'(zf) - 33'(zn);
        d_in.sx     = 33'(a2) + 33'(a1);
        d_in.sy     = 33'(a4) + 33'(a3);
        d_in.sz     = 33'(zf) + 33'(zn);
        d_in.fn     = 64'(mag32(zf)) * 64'(mag32(zn));
        d_in.fn_neg = zf[31] ^ zn[31];
        d_in.zn     = zn;
        d_in.a1     = a1;
        d_in.a2     = a2;
        d_in.a3     = a3;
        d_in.a4     = a4;
        d_in.mode   = MODE_IDENT;
        if (s_tuser == FUNC_ORTHO && d_in.dx != 0 && d_in.dy != 0 && d_in.dz != 0)
        begin
            d_in.mode = MODE_ORTHO;
        end
        else if (s_tuser == FUNC_FRUST && d_in.dx != 0 && d_in.dy != 0 && d_in.dz != 0)
        begin
            d_in.mode = MODE_FRUST;
        end
        else if (s_tuser == FUNC_PERSP && d_in.dz != 0)
        begin
            d_in.mode = MODE_PERSP;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_desc   = q_reg[rd_ptr_reg];

    // queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= d_in;
        end
    end

endmodule
`default_nettype wire

>>> design/pmb_div.sv
// restoring divider: 33 quotient bits, one per cycle, with saturation to 32 bits
`default_nettype none
module pmb_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire pmb_pkg::div_req_t     req,
    output pmb_pkg::div_rsp_t          rsp
);
    import pmb_pkg::*;

    logic [96:0] num_sh;
    logic [63:0] hi_reg;
    logic [32:0] lo_reg;
    logic [33:0] den_reg;
    logic [33:0] rem_reg;
    logic [32:0] q_reg;
    logic        neg_reg, ovf_reg;
    logic        chk_reg, run_reg, fin_reg;
    logic [5:0]  cnt_reg;
    logic [34:0] rem_try;
    logic        take;
    logic [32:0] lim;
    logic        sat;

    assign num_sh  = {33'd0, req.num} << req.shift;
    assign rem_try = {rem_reg, lo_reg[32]};
    assign take    = (rem_try >= {1'b0, den_reg});
    assign lim     = neg_reg ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
    assign sat     = ovf_reg || (q_reg > lim);

    // result formatting
    always_comb
    begin
        rsp.done = fin_reg;
        rsp.sat  = sat;
        if (sat)
        begin
            rsp.value = neg_reg ? NEG_MAX : POS_MAX;
        end
        else
        begin
            rsp.value = neg_reg ? 32'(-q_reg[31:0]) : q_reg[31:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_reg <= 1'b0;
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                chk_reg <= 1'b1;
            end
            else if (chk_reg)
            begin
                chk_reg <= 1'b0;
                run_reg <= 1'b1;
                cnt_reg <= 6'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg  <= num_sh[96:33];
            lo_reg  <= num_sh[32:0];
            den_reg <= req.den;
            neg_reg <= req.neg;
        end
        else if (chk_reg)
        begin
            ovf_reg <= (hi_reg >= {30'd0, den_reg});
            rem_reg <= hi_reg[33:0];
            q_reg   <= 33'd0;
        end
        else if (run_reg)
        begin
            rem_reg <= take ? 34'(rem_try - {1'b0, den_reg}) : rem_try[33:0];
            lo_reg  <= {lo_reg[31:0], 1'b0};
            q_reg   <= {q_reg[31:0], take};
        end
    end

endmodule
`default_nettype wire

>>> design/pmb_back.sv
// sequencer: angle reduction, cordic cot(fovy/2) and the list of divisions per kind
`default_nettype none
module pmb_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire pmb_pkg::desc_t        q_desc,
    output logic                       q_pop,
    output logic                       div_start,
    output pmb_pkg::div_req_t          div_req,
    input  wire pmb_pkg::div_rsp_t     div_rsp,
    input  wire logic                  emit_idle,
    output logic                       hand_valid,
    output pmb_pkg::mat_t              mat_out,
    output logic                       degen_out
);
    import pmb_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_FIX      = 3'd2;
    localparam logic [2:0] ST_CORDIC   = 3'd3;
    localparam logic [2:0] ST_DIV_GO   = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]         state_reg, state_next;
    desc_t              cur_reg;
    mat_t               mat_reg;
    logic               degen_reg;
    logic [2:0]         op_reg;
    logic [4:0]         k_reg;
    logic [46:0]        rmag_reg;
    logic               rneg_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [35:0] z_reg;

    logic [46:0]        pi_sh;
    logic [32:0]        rm;
    logic [32:0]        rfold;
    logic signed [33:0] xs, ys;
    logic signed [35:0] ang;
    logic [3:0]         dst;
    logic [2:0]         last_op;
    logic               c_neg;
    logic [32:0]        c_mag;
    logic [33:0]        x_mag, y_mag;
    mat_t               mat_init;

    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign div_start  = (state_reg == ST_DIV_GO);
    assign hand_valid = (state_reg == ST_DONE) && emit_idle;
    assign mat_out    = mat_reg;
    assign degen_out  = degen_reg;

    // angle and cordic step terms
    always_comb
    begin
        pi_sh = PI_Q31 << k_reg;
        rm    = rmag_reg[32:0];
        rfold = (rneg_reg && rm != 33'd0) ? 33'(PI_Q31[32:0] - rm) : rm;
        xs    = x_reg >>> k_reg;
        ys    = y_reg >>> k_reg;
        ang   = 36'(atan_q31(k_reg));
        x_mag = x_reg[33] ? 34'(-x_reg) : 34'(x_reg);
        y_mag = y_reg[33] ? 34'(-y_reg) : 34'(y_reg);
        c_neg = mat_reg[5][31];
        c_mag = c_neg ? 33'(-{1'b1, mat_reg[5]}) : {1'b0, mat_reg[5]};
    end

    // starting matrix for a new item: identity, projective row, principal point
    always_comb
    begin
        mat_init     = '0;
        mat_init[0]  = ONE_FIX;
        mat_init[5]  = ONE_FIX;
        mat_init[10] = ONE_FIX;
        mat_init[15] = ONE_FIX;
        if (q_desc.mode == MODE_FRUST || q_desc.mode == MODE_PERSP)
        begin
            mat_init[14] = NEG_ONE_FIX;
            mat_init[15] = 32'd0;
        end
        if (q_desc.mode == MODE_PERSP)
        begin
            mat_init[2] = q_desc.a1;
            mat_init[6] = q_desc.a2;
        end
    end

    // division list per kind
    always_comb
    begin
        div_req = '0;
        dst     = 4'd0;
        last_op = (cur_reg.mode == MODE_PERSP) ? 3'd3 : 3'd5;
        case (cur_reg.mode)
            MODE_ORTHO:
            begin
                case (op_reg)
                    3'd0:
                    begin
                        div_req = '{64'd1, 6'd33, 34'(mag33(cur_reg.dx)), cur_reg.dx[32]};
                        dst = 4'd0;
                    end
                    3'd1:
                    begin
                        div_req = '{64'd1, 6'd33, 34'(mag33(cur_reg.dy)), cur_reg.dy[32]};
                        dst = 4'd5;
                    end
                    3'd2:
                    begin
                        div_req = '{64'd1, 6'd33, 34'(mag33(cur_reg.dz)), !cur_reg.dz[32]};
                        dst = 4'd10;
                    end
                    3'd3:
                    begin
                        div_req = '{64'(mag33(cur_reg.sx)), 6'd16, 34'(mag33(cur_reg.dx)),
                                    !(cur_reg.sx[32] ^ cur_reg.dx[32])};
                        dst = 4'd3;
                    end
                    3'd4:
                    begin
                        div_req = '{64'(mag33(cur_reg.sy)), 6'd16, 34'(mag33(cur_reg.dy)),
                                    !(cur_reg.sy[32] ^ cur_reg.dy[32])};
                        dst = 4'd7;
                    end
                    default:
                    begin
                        div_req = '{64'(mag33(cur_reg.sz)), 6'd16, 34'(mag33(cur_reg.dz)),
                                    !(cur_reg.sz[32] ^ cur_reg.dz[32])};
                        dst = 4'd11;
                    end
                endcase
            end
            MODE_FRUST:
            begin
                case (op_reg)
                    3'd0:
                    begin
                        div_req = '{64'(mag32(cur_reg.zn)), 6'd17, 34'(mag33(cur_reg.dx)),
                                    cur_reg.zn[31] ^ cur_reg.dx[32]};
                        dst = 4'd0;
                    end
                    3'd1:
                    begin
                        div_req = '{64'(mag32(cur_reg.zn)), 6'd17, 34'(mag33(cur_reg.dy)),
                                    cur_reg.zn[31] ^ cur_reg.dy[32]};
                        dst = 4'd5;
                    end
                    3'd2:
                    begin
                        div_req = '{64'(mag33(cur_reg.sx)), 6'd16, 34'(mag33(cur_reg.dx)),
                                    cur_reg.sx[32] ^ cur_reg.dx[32]};
                        dst = 4'd2;
                    end
                    3'd3:
                    begin
                        div_req = '{64'(mag33(cur_reg.sy)), 6'd16, 34'(mag33(cur_reg.dy)),
                                    cur_reg.sy[32] ^ cur_reg.dy[32]};
                        dst = 4'd6;
                    end
                    3'd4:
                    begin
                        div_req = '{64'(mag33(cur_reg.sz)), 6'd16, 34'(mag33(cur_reg.dz)),
                                    !(cur_reg.sz[32] ^ cur_reg.dz[32])};
                        dst = 4'd10;
                    end
                    default:
                    begin
                        div_req = '{cur_reg.fn, 6'd1, 34'(mag33(cur_reg.dz)),
                                    !(cur_reg.fn_neg ^ cur_reg.dz[32])};
                        dst = 4'd11;
                    end
                endcase
            end
            MODE_PERSP:
            begin
                case (op_reg)
                    3'd0:
                    begin
                        div_req = '{64'(x_mag), 6'd16, y_mag, x_reg[33] ^ y_reg[33]};
                        dst = 4'd5;
                    end
                    3'd1:
                    begin
                        div_req = '{64'(c_mag), 6'd16, 34'(mag32(cur_reg.a4)),
                                    c_neg ^ cur_reg.a4[31]};
                        dst = 4'd0;
                    end
                    3'd2:
                    begin
                        div_req = '{64'(mag33(cur_reg.sz)), 6'd16, 34'(mag33(cur_reg.dz)),
                                    !(cur_reg.sz[32] ^ cur_reg.dz[32])};
                        dst = 4'd10;
                    end
                    default:
                    begin
                        div_req = '{cur_reg.fn, 6'd1, 34'(mag33(cur_reg.dz)),
                                    !(cur_reg.fn_neg ^ cur_reg.dz[32])};
                        dst = 4'd11;
                    end
                endcase
            end
            default:
            begin
                div_req = '0;
                dst     = 4'd0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_desc.mode)
                        MODE_IDENT: state_next = ST_DONE;
                        MODE_PERSP: state_next = ST_RANGE;
                        default:    state_next = ST_DIV_GO;
                    endcase
                end
            end
            ST_RANGE:
            begin
                if (k_reg == 5'd0)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (k_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (op_reg == last_op) ? ST_DONE : ST_DIV_GO;
                end
            end
            ST_DONE:
            begin
                if (emit_idle)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg   <= q_desc;
                op_reg    <= 3'd0;
                k_reg     <= 5'(RANGE_STEPS - 1);
                rmag_reg  <= 47'(mag32(q_desc.a3)) << (30 - FRAC_BITS);
                rneg_reg  <= q_desc.a3[31];
                degen_reg <= (q_desc.mode == MODE_IDENT);
                mat_reg   <= mat_init;
            end
            ST_RANGE:
            begin
                if (rmag_reg >= pi_sh)
                begin
                    rmag_reg <= rmag_reg - pi_sh;
                end
                k_reg <= k_reg - 5'd1;
            end
            ST_FIX:
            begin
                x_reg <= 34'sd1073741824;
                y_reg <= 34'sd0;
                k_reg <= 5'd0;
                if (rfold > HALF_PI_Q31)
                begin
                    z_reg <= 36'(rfold) - 36'(PI_Q31[32:0]);
                end
                else
                begin
                    z_reg <= 36'(rfold);
                end
            end
            ST_CORDIC:
            begin
                k_reg <= k_reg + 5'd1;
                if (!z_reg[35])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mat_reg[dst] <= div_rsp.value;
                    degen_reg    <= degen_reg | div_rsp.sat;
                    op_reg       <= op_reg + 3'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/pmb_emit.sv
// result side: holds a finished matrix and sends its sixteen elements in order
`default_nettype none
module pmb_emit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire pmb_pkg::mat_t         mat_in,
    input  wire logic                  degen_in,
    output logic                       idle,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata,
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser
);
    import pmb_pkg::*;

    mat_t        mat_reg;
    logic        degen_reg;
    logic        busy_reg;
    logic [3:0]  idx_reg;
    logic        ov_reg;
    logic [3:0]  oidx_reg;
    logic [31:0] oval_reg;
    logic        olast_reg;
    logic        odeg_reg;
    logic        adv;

    assign idle     = !busy_reg;
    assign adv      = busy_reg && (!ov_reg || m_tready);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, oval_reg, oidx_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = odeg_reg;

    // element counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 4'd0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 4'd0;
            end
            else if (adv)
            begin
                idx_reg <= idx_reg + 4'd1;
                if (idx_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // matrix hold and output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mat_reg   <= mat_in;
            degen_reg <= degen_in;
        end
        if (adv)
        begin
            oidx_reg  <= idx_reg;
            oval_reg  <= mat_reg[idx_reg];
            olast_reg <= (idx_reg == 4'd15);
            odeg_reg  <= degen_reg;
        end
    end

endmodule
`default_nettype wire
